FILE: hw/rtl/lbc_pkg.sv
// Shared types and codes for the LRU block cache.
package lbc_pkg;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;
	localparam logic [1:0] CMD_SKIP   = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_DUP  = 2'd2;
	localparam logic [1:0] ST_OFF  = 2'd3;

	localparam logic REG_CACHE_ON = 1'b0;
	localparam logic REG_ACTIVE   = 1'b1;

	localparam int TAG_W   = 12;
	localparam int WORD_W  = 64;
	localparam int CFG_W   = 9;
	localparam int COUNT_W = 32;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  disk_id;
		logic [7:0]  block_id;
		logic [63:0] data_word;
		logic        last_word;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] read_word;
		logic        final_result;
		logic [31:0] hit_count;
		logic [31:0] query_count;
	} rsp_t;

	typedef struct packed {
		logic       item_load;
		logic       stage_wr;
		logic       stage_clr;
		logic       lookup_inc;
		logic       scan_start;
		logic       scan_step;
		logic       decide;
		logic       stamp_we;
		logic       tag_we;
		logic       hit_inc;
		logic       copy_issue;
		logic       word_read;
		logic       w_inc;
		logic       load_single;
		logic       load_word;
		logic [1:0] status;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] item_cmd;
		logic       item_last;
		logic       cache_on;
		logic       match_found;
		logic       scan_last;
		logic       w_last;
		logic       out_free;
	} ctl_sts_t;

endpackage

FILE: hw/rtl/lru_block_cache.sv
// Top level of the fully associative LRU disk-block cache.
// With the cache on, each lookup, and each last word of an insert or update,
// scans the tag and stamp memories one entry per cycle over the live entry
// count; a hit then streams BLOCK_WORDS words, each through a block memory
// read and the output register, and an insert or update copies the staged
// block into the entry. A non-final word of an insert or update is staged
// with no result. One item is worked on at a time; req_stall is high while
// busy. Any configuration write clears every valid mark. Entries are chosen
// as the first free one, else the oldest use stamp with the lowest index on
// ties.
module lru_block_cache #(
	parameter int MAX_ENTRIES = 256,
	parameter int BLOCK_WORDS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  lbc_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output lbc_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [lbc_pkg::CFG_W-1:0] cfg_data
);

	lbc_pkg::ctl_cmd_t cmd;
	lbc_pkg::ctl_sts_t sts;

	// Sequence each word through decode, scan, decide, copy and send.
	lbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the memories, counters and the output register.
	lbc_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.BLOCK_WORDS (BLOCK_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: hw/rtl/lbc_ram.sv
// Generic simple dual-port RAM with registered read.
module lbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/lbc_ctrl.sv
// Sequencer for lookups, staging, scans, block copies and result delivery.
module lbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  lbc_pkg::ctl_sts_t sts,
	output lbc_pkg::ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN, S_SCAN_END, S_DECIDE,
		S_COPY, S_COPY_END, S_READ, S_SEND_WORD, S_SEND
	} state_t;

	state_t     state_q;
	logic [1:0] res_q;

	logic is_lookup;
	logic is_insert;
	logic is_update;

	assign is_lookup = sts.item_cmd == lbc_pkg::CMD_LOOKUP;
	assign is_insert = sts.item_cmd == lbc_pkg::CMD_INSERT;
	assign is_update = sts.item_cmd == lbc_pkg::CMD_UPDATE;

	assign req_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= lbc_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (!is_lookup && !is_insert && !is_update) begin
						state_q <= S_IDLE;
					end else if (!sts.cache_on) begin
						res_q   <= lbc_pkg::ST_OFF;
						state_q <= (is_lookup || sts.item_last) ? S_SEND : S_IDLE;
					end else if (!is_lookup && !sts.item_last) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.scan_last) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (is_lookup) begin
						if (sts.match_found) begin
							res_q   <= lbc_pkg::ST_OK;
							state_q <= S_READ;
						end else begin
							res_q   <= lbc_pkg::ST_MISS;
							state_q <= S_SEND;
						end
					end else if (is_update) begin
						res_q   <= sts.match_found ? lbc_pkg::ST_OK : lbc_pkg::ST_MISS;
						state_q <= sts.match_found ? S_COPY : S_SEND;
					end else begin
						res_q   <= sts.match_found ? lbc_pkg::ST_DUP : lbc_pkg::ST_OK;
						state_q <= sts.match_found ? S_SEND : S_COPY;
					end
				end
				S_COPY: begin
					if (sts.w_last) begin
						state_q <= S_COPY_END;
					end
				end
				S_COPY_END: begin
					state_q <= S_SEND;
				end
				S_READ: begin
					state_q <= S_SEND_WORD;
				end
				S_SEND_WORD: begin
					if (sts.out_free) begin
						state_q <= sts.w_last ? S_IDLE : S_READ;
					end
				end
				S_SEND: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.status = res_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.item_load = req_valid;
			end
			S_DECODE: begin
				if (is_lookup || is_insert || is_update) begin
					if (!sts.cache_on) begin
						cmd.stage_clr = !is_lookup;
					end else begin
						cmd.stage_wr   = !is_lookup;
						cmd.lookup_inc = is_lookup;
						cmd.scan_start = is_lookup || sts.item_last;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (is_lookup) begin
					cmd.hit_inc  = sts.match_found;
					cmd.stamp_we = sts.match_found;
				end else if (is_update) begin
					cmd.stamp_we = sts.match_found;
				end else begin
					cmd.tag_we   = !sts.match_found;
					cmd.stamp_we = !sts.match_found;
				end
			end
			S_COPY: begin
				cmd.copy_issue = 1'b1;
				cmd.w_inc      = !sts.w_last;
			end
			S_READ: begin
				cmd.word_read = 1'b1;
			end
			S_SEND_WORD: begin
				cmd.load_word = sts.out_free;
				cmd.w_inc     = sts.out_free && !sts.w_last;
			end
			S_SEND: begin
				cmd.load_single = sts.out_free;
				cmd.stage_clr   = sts.out_free && !is_lookup;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/lbc_dp.sv
// Datapath: registers, tag/stamp/block memories, scan and copy logic.
module lbc_dp #(
	parameter int MAX_ENTRIES = 256,
	parameter int BLOCK_WORDS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lbc_pkg::req_t                    req,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [lbc_pkg::CFG_W-1:0]        cfg_data,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output lbc_pkg::rsp_t                    rsp,
	input  lbc_pkg::ctl_cmd_t                cmd,
	output lbc_pkg::ctl_sts_t                sts
);

	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int WW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int CW = $clog2(BLOCK_WORDS + 1);
	localparam int AW = $clog2(MAX_ENTRIES * BLOCK_WORDS);

	lbc_pkg::req_t item_q;
	logic          cache_on_q;
	logic [lbc_pkg::CFG_W-1:0] active_q;
	logic [MAX_ENTRIES-1:0]    valid_q;

	logic [31:0]   act_ext;
	logic [31:0]   n_ext;
	logic [EW-1:0] last_idx;

	logic [EW-1:0] scan_i_q;
	logic          eval_s1;
	logic [EW-1:0] idx_s1;
	logic          match_have_q, free_have_q, min_have_q;
	logic [EW-1:0] match_q, free_q, min_q;
	logic [31:0]   min_stamp_q;
	logic [EW-1:0] target;

	logic [lbc_pkg::TAG_W-1:0] item_tag;
	logic [lbc_pkg::TAG_W-1:0] tag_rdata;
	logic [31:0]               stamp_rdata;

	logic [CW-1:0]  stage_cnt_q;
	logic [WW-1:0]  w_q;
	logic [WW-1:0]  w_s1;
	logic           copy_s1;
	logic [AW-1:0]  base_q;
	logic [63:0]    stg_rdata;
	logic [63:0]    blk_rdata;
	logic [63:0]    blk_wdata;
	logic           stage_we;

	logic [31:0] clock_q;
	logic [31:0] hits_q;
	logic [31:0] lookups_q;

	lbc_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	assign item_tag = {item_q.disk_id, item_q.block_id};

	// Clamp the live entry count to the built range.
	assign act_ext  = {{(32 - lbc_pkg::CFG_W){1'b0}}, active_q};
	assign n_ext    = (act_ext < 32'd2) ? 32'd2 :
	                  (act_ext > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : act_ext;
	assign last_idx = EW'(n_ext - 32'd1);

	assign target = (item_q.command == lbc_pkg::CMD_INSERT) ?
	                (free_have_q ? free_q : min_q) : match_q;

	assign stage_we  = cmd.stage_wr && (stage_cnt_q < CW'(BLOCK_WORDS));
	assign blk_wdata = (CW'(w_s1) < stage_cnt_q) ? stg_rdata : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_on_q   <= 1'b0;
			active_q     <= lbc_pkg::CFG_W'(2);
			valid_q      <= '0;
			scan_i_q     <= '0;
			eval_s1      <= 1'b0;
			match_have_q <= 1'b0;
			free_have_q  <= 1'b0;
			min_have_q   <= 1'b0;
			stage_cnt_q  <= '0;
			w_q          <= '0;
			copy_s1      <= 1'b0;
			clock_q      <= '0;
			hits_q       <= '0;
			lookups_q    <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				valid_q <= '0;
				if (cfg_index == lbc_pkg::REG_CACHE_ON) begin
					cache_on_q <= cfg_data[0];
				end else begin
					active_q <= cfg_data;
				end
			end else if (cmd.tag_we) begin
				valid_q[target] <= 1'b1;
			end

			if (cmd.stage_clr) begin
				stage_cnt_q <= '0;
			end else if (stage_we) begin
				stage_cnt_q <= stage_cnt_q + CW'(1);
			end

			eval_s1 <= cmd.scan_step;
			if (cmd.scan_start) begin
				scan_i_q     <= '0;
				match_have_q <= 1'b0;
				free_have_q  <= 1'b0;
				min_have_q   <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					scan_i_q <= scan_i_q + EW'(1);
				end
				if (eval_s1) begin
					if (valid_q[idx_s1] && tag_rdata == item_tag && !match_have_q) begin
						match_have_q <= 1'b1;
					end
					if (!valid_q[idx_s1] && !free_have_q) begin
						free_have_q <= 1'b1;
					end
					if (valid_q[idx_s1] && (!min_have_q || stamp_rdata < min_stamp_q)) begin
						min_have_q <= 1'b1;
					end
				end
			end

			if (cmd.decide) begin
				w_q <= '0;
			end else if (cmd.w_inc) begin
				w_q <= w_q + WW'(1);
			end
			copy_s1 <= cmd.copy_issue;

			if (cmd.stamp_we) begin
				clock_q <= clock_q + 32'd1;
			end
			if (cmd.hit_inc) begin
				hits_q <= hits_q + 32'd1;
			end
			if (cmd.lookup_inc) begin
				lookups_q <= lookups_q + 32'd1;
			end

			if (cmd.load_single || cmd.load_word) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= req;
		end
		idx_s1 <= scan_i_q;
		w_s1   <= w_q;
		if (eval_s1) begin
			if (valid_q[idx_s1] && tag_rdata == item_tag && !match_have_q) begin
				match_q <= idx_s1;
			end
			if (!valid_q[idx_s1] && !free_have_q) begin
				free_q <= idx_s1;
			end
			if (valid_q[idx_s1] && (!min_have_q || stamp_rdata < min_stamp_q)) begin
				min_q       <= idx_s1;
				min_stamp_q <= stamp_rdata;
			end
		end
		if (cmd.decide) begin
			base_q <= AW'(target) * AW'(BLOCK_WORDS);
		end
		if (cmd.load_single) begin
			rsp_q.status       <= cmd.status;
			rsp_q.read_word    <= '0;
			rsp_q.final_result <= 1'b1;
			rsp_q.hit_count    <= hits_q;
			rsp_q.query_count  <= lookups_q;
		end else if (cmd.load_word) begin
			rsp_q.status       <= lbc_pkg::ST_OK;
			rsp_q.read_word    <= blk_rdata;
			rsp_q.final_result <= w_q == WW'(BLOCK_WORDS - 1);
			rsp_q.hit_count    <= hits_q;
			rsp_q.query_count  <= lookups_q;
		end
	end

	lbc_ram #(.WIDTH(lbc_pkg::TAG_W), .DEPTH(MAX_ENTRIES)) u_tag_ram (
		.clk   (clk),
		.we    (cmd.tag_we),
		.waddr (target),
		.wdata (item_tag),
		.re    (cmd.scan_step),
		.raddr (scan_i_q),
		.rdata (tag_rdata)
	);

	lbc_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_stamp_ram (
		.clk   (clk),
		.we    (cmd.stamp_we),
		.waddr (target),
		.wdata (clock_q),
		.re    (cmd.scan_step),
		.raddr (scan_i_q),
		.rdata (stamp_rdata)
	);

	lbc_ram #(.WIDTH(lbc_pkg::WORD_W), .DEPTH(BLOCK_WORDS)) u_stage_ram (
		.clk   (clk),
		.we    (stage_we),
		.waddr (stage_cnt_q[WW-1:0]),
		.wdata (item_q.data_word),
		.re    (cmd.copy_issue),
		.raddr (w_q),
		.rdata (stg_rdata)
	);

	lbc_ram #(.WIDTH(lbc_pkg::WORD_W), .DEPTH(MAX_ENTRIES * BLOCK_WORDS)) u_blk_ram (
		.clk   (clk),
		.we    (copy_s1),
		.waddr (base_q + AW'(w_s1)),
		.wdata (blk_wdata),
		.re    (cmd.word_read),
		.raddr (base_q + AW'(w_q)),
		.rdata (blk_rdata)
	);

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign sts.item_cmd    = item_q.command;
	assign sts.item_last   = item_q.last_word;
	assign sts.cache_on    = cache_on_q;
	assign sts.match_found = match_have_q;
	assign sts.scan_last   = scan_i_q == last_idx;
	assign sts.w_last      = w_q == WW'(BLOCK_WORDS - 1);
	assign sts.out_free    = !rsp_valid_q;

`ifndef SYNTHESIS
	a_stage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stage_cnt_q <= CW'(BLOCK_WORDS))
		else $error("staging count beyond block size");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_single || cmd.load_word) |-> !rsp_valid_q)
		else $error("result loaded over a pending word");
	a_hit_has_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit_inc |-> match_have_q)
		else $error("hit counted without a matching entry");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the LRU block cache.
`timescale 1ns / 1ps
module tb;

	localparam int N_ENT  = 256;
	localparam int N_WORD = 32;
	localparam int WATCHDOG = 200000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	lbc_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	lbc_pkg::rsp_t rsp;
	logic cfg_we;
	logic cfg_index;
	logic [lbc_pkg::CFG_W-1:0] cfg_data;

	lru_block_cache u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the cache state.
	logic            sh_on;
	logic [8:0]      sh_active;
	logic            sh_valid [N_ENT];
	logic [11:0]     sh_tag   [N_ENT];
	logic [31:0]     sh_stamp [N_ENT];
	logic [63:0]     sh_data  [N_ENT*N_WORD];
	logic [63:0]     sh_stage [N_WORD];
	int unsigned     sh_stage_n;
	logic [31:0]     sh_clock;
	logic [31:0]     sh_hits;
	logic [31:0]     sh_lookups;

	lbc_pkg::rsp_t want_q[$];
	int   mismatches;
	bit   quiet;
	int   stall_left;
	int   idle_cycles;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int live_count();
		int n;
		n = sh_active;
		if (n < 2) n = 2;
		if (n > N_ENT) n = N_ENT;
		return n;
	endfunction

	function automatic int find_tag(logic [11:0] t);
		for (int i = 0; i < live_count(); i++)
			if (sh_valid[i] && sh_tag[i] == t) return i;
		return -1;
	endfunction

	function automatic lbc_pkg::rsp_t make_word(logic [1:0] st, logic [63:0] w, logic fin);
		lbc_pkg::rsp_t r;
		r.status = st;
		r.read_word = w;
		r.final_result = fin;
		r.hit_count = sh_hits;
		r.query_count = sh_lookups;
		return r;
	endfunction

	function automatic void commit_block(int e);
		for (int w = 0; w < N_WORD; w++)
			sh_data[e*N_WORD+w] = (w < sh_stage_n) ? sh_stage[w] : 64'd0;
		sh_stamp[e] = sh_clock;
		sh_clock++;
	endfunction

	// Work out the words one request causes and queue them.
	function automatic void predict_cache(lbc_pkg::req_t r);
		logic [11:0] t;
		int e;
		int vic;
		bit free;
		t = {r.disk_id, r.block_id};
		if (r.command == lbc_pkg::CMD_SKIP) return;
		if (r.command == lbc_pkg::CMD_LOOKUP) begin
			if (!sh_on) begin
				want_q.push_back(make_word(lbc_pkg::ST_OFF, 0, 1));
				return;
			end
			sh_lookups++;
			e = find_tag(t);
			if (e < 0) begin
				want_q.push_back(make_word(lbc_pkg::ST_MISS, 0, 1));
				return;
			end
			sh_hits++;
			sh_stamp[e] = sh_clock;
			sh_clock++;
			for (int w = 0; w < N_WORD; w++)
				want_q.push_back(make_word(lbc_pkg::ST_OK, sh_data[e*N_WORD+w],
					w == N_WORD-1));
			return;
		end
		if (!sh_on) begin
			sh_stage_n = 0;
			if (r.last_word) want_q.push_back(make_word(lbc_pkg::ST_OFF, 0, 1));
			return;
		end
		if (sh_stage_n < N_WORD) begin
			sh_stage[sh_stage_n] = r.data_word;
			sh_stage_n++;
		end
		if (!r.last_word) return;
		e = find_tag(t);
		if (r.command == lbc_pkg::CMD_UPDATE) begin
			if (e < 0) want_q.push_back(make_word(lbc_pkg::ST_MISS, 0, 1));
			else begin
				commit_block(e);
				want_q.push_back(make_word(lbc_pkg::ST_OK, 0, 1));
			end
		end else if (e >= 0) begin
			want_q.push_back(make_word(lbc_pkg::ST_DUP, 0, 1));
		end else begin
			vic = 0;
			free = 0;
			for (int i = 0; i < live_count(); i++)
				if (!free && !sh_valid[i]) begin
					vic = i;
					free = 1;
				end
			if (!free)
				for (int i = 1; i < live_count(); i++)
					if (sh_stamp[i] < sh_stamp[vic]) vic = i;
			sh_tag[vic] = t;
			sh_valid[vic] = 1;
			commit_block(vic);
			want_q.push_back(make_word(lbc_pkg::ST_OK, 0, 1));
		end
		sh_stage_n = 0;
	endfunction

	// Response side: random stall bursts, compare every accepted word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (want_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %p", rsp);
				end else begin
					if (rsp !== want_q[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", want_q[0], rsp);
					end
					void'(want_q.pop_front());
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			// hold stall for a burst, then release
			if (quiet) rsp_stall <= 1'b0;
			else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_stall <= 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 16);
				rsp_stall <= 1'b1;
			end else rsp_stall <= 1'b0;
		end
	end

	// Watchdog: give up when nothing moves for too long.
	always @(posedge clk) begin
		if (idle_cycles > WATCHDOG) begin
			$display("lru_block_cache test failed");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [lbc_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lbc_pkg::REG_CACHE_ON) sh_on = val[0];
		else sh_active = val;
		for (int i = 0; i < N_ENT; i++) sh_valid[i] = 0;
	endtask

	// Offer one word and wait for its acceptance; optional gap first.
	task automatic send_word(lbc_pkg::req_t r, bit gaps);
		if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		predict_cache(r);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		// let a trailing non-final word settle
		repeat (N_ENT + 80) @(posedge clk);
	endtask

	function automatic lbc_pkg::req_t mk(logic [1:0] c, logic [3:0] d, logic [7:0] b,
		logic [63:0] w, logic l);
		lbc_pkg::req_t r;
		r.command = c;
		r.disk_id = d;
		r.block_id = b;
		r.data_word = w;
		r.last_word = l;
		return r;
	endfunction

	// Stream a block of len words for one tag.
	task automatic send_block(logic [1:0] c, logic [11:0] t, int len);
		for (int k = 0; k < len; k++)
			send_word(mk(c, t[11:8], t[7:0], {$urandom, $urandom}, k == len-1), 1);
	endtask

	typedef struct {
		lbc_pkg::req_t r;
		bit            typed;
		logic [1:0]    st;
	} row_t;

	row_t dir_rows[$];
	lbc_pkg::rsp_t first;

	initial begin
		arst_n = 0;
		req_valid = 0;
		req = '0;
		rsp_stall = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = '0;
		mismatches = 0;
		quiet = 0;
		stall_left = 0;
		idle_cycles = 0;
		sh_on = 0;
		sh_active = 2;
		sh_stage_n = 0;
		sh_clock = 0;
		sh_hits = 0;
		sh_lookups = 0;
		for (int i = 0; i < N_ENT; i++) begin
			sh_valid[i] = 0;
			sh_stamp[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed table: cache off after reset, then extremes and special cases.
		dir_rows.push_back('{mk(lbc_pkg::CMD_LOOKUP, 4'd0, 8'd0, 0, 0), 1, lbc_pkg::ST_OFF});
		dir_rows.push_back('{mk(lbc_pkg::CMD_INSERT, 4'd15, 8'd255, '1, 0), 0, 0});
		dir_rows.push_back('{mk(lbc_pkg::CMD_UPDATE, 4'd15, 8'd255, '1, 1), 1, lbc_pkg::ST_OFF});
		dir_rows.push_back('{mk(lbc_pkg::CMD_SKIP, 4'd1, 8'd1, 0, 1), 0, 0});
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].r, 0);
			if (dir_rows[i].typed) begin
				first = want_q[$];
				if (first.status !== dir_rows[i].st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("status mismatch: expected %0d actual %0d",
							dir_rows[i].st, first.status);
				end
			end
		end
		drain_results();

		write_reg(lbc_pkg::REG_CACHE_ON, 1);
		write_reg(lbc_pkg::REG_ACTIVE, 0);
		dir_rows.delete();
		dir_rows.push_back('{mk(lbc_pkg::CMD_LOOKUP, 4'd15, 8'd255, 0, 0), 1, lbc_pkg::ST_MISS});
		dir_rows.push_back('{mk(lbc_pkg::CMD_UPDATE, 4'd15, 8'd255, 0, 1), 1, lbc_pkg::ST_MISS});
		dir_rows.push_back('{mk(lbc_pkg::CMD_INSERT, 4'd15, 8'd255, '1, 1), 1, lbc_pkg::ST_OK});
		dir_rows.push_back('{mk(lbc_pkg::CMD_INSERT, 4'd15, 8'd255, 0, 1), 1, lbc_pkg::ST_DUP});
		dir_rows.push_back('{mk(lbc_pkg::CMD_LOOKUP, 4'd15, 8'd255, 0, 0), 0, 0});
		dir_rows.push_back('{mk(lbc_pkg::CMD_INSERT, 4'd0, 8'd0, 64'h5, 0), 0, 0});
		dir_rows.push_back('{mk(lbc_pkg::CMD_UPDATE, 4'd0, 8'd0, 64'h6, 0), 0, 0});
		dir_rows.push_back('{mk(lbc_pkg::CMD_INSERT, 4'd0, 8'd0, 64'h7, 1), 0, 0});
		dir_rows.push_back('{mk(lbc_pkg::CMD_INSERT, 4'd1, 8'd2, 64'h8, 1), 0, 0});
		dir_rows.push_back('{mk(lbc_pkg::CMD_LOOKUP, 4'd15, 8'd255, 0, 0), 1, lbc_pkg::ST_MISS});
		dir_rows.push_back('{mk(lbc_pkg::CMD_LOOKUP, 4'd0, 8'd0, 0, 1), 0, 0});
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].r, 0);
			if (dir_rows[i].typed) begin
				first = want_q[$];
				if (first.status !== dir_rows[i].st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("status mismatch: expected %0d actual %0d",
							dir_rows[i].st, first.status);
				end
			end
		end
		// overlong block
		send_block(lbc_pkg::CMD_UPDATE, 12'h000, N_WORD + 3);
		send_word(mk(lbc_pkg::CMD_LOOKUP, 4'd0, 8'd0, 0, 0), 0);
		drain_results();

		// Random phases over several sizes, the largest included.
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 3) write_reg(lbc_pkg::REG_ACTIVE, 9'd256);
			else write_reg(lbc_pkg::REG_ACTIVE, $urandom_range(2, 6));
			write_reg(lbc_pkg::REG_CACHE_ON, ph != 1 || $urandom_range(0, 1));
			if (ph == 3) quiet = 1;
			for (int n = 0; n < 6; n++) begin
				logic [11:0] t;
				t = {$urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'd3,
					$urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7))};
				case ($urandom_range(0, 9))
					0, 1, 2, 3: send_word(mk(lbc_pkg::CMD_LOOKUP, t[11:8], t[7:0],
						{$urandom, $urandom}, 1'($urandom)), 1);
					4, 5: send_block(lbc_pkg::CMD_INSERT, t, $urandom_range(0, 7) == 0
						? N_WORD : $urandom_range(1, 3));
					6, 7: send_block(lbc_pkg::CMD_UPDATE, t, $urandom_range(1, 3));
					8: send_word(mk(2'($urandom_range(1, 3)), t[11:8], t[7:0],
						{$urandom, $urandom}, 1'($urandom)), 1);
					default: send_block(2'($urandom_range(1, 2)), t, $urandom_range(1, 4));
				endcase
			end
			drain_results();
		end
		req_valid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (N_ENT + 80) @(posedge clk);
		if (mismatches == 0 && want_q.size() == 0) begin
			$display("lru_block_cache test passed");
		end else begin
			$display("lru_block_cache test failed");
		end
		$finish;
	end

endmodule
